// ===== design/assert_macros.svh =====
// Assertion macros shared by the deque RTL.
// Each macro builds one labeled concurrent assertion that reports through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== design/cdq_pkg.sv =====
// Shared types and constants for the circular deque.
// No dependencies; used by every module of the block.
`default_nettype none

package cdq_pkg;

   localparam int DEPTH_DEF      = 16;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int OP_W           = 3;
   localparam int XDATA_W        = 32;   // data width on the ports
   localparam int STATUS_W       = 2;
   localparam int MODE_W         = 2;
   localparam int OCC_W          = 5;

   typedef enum logic [OP_W-1:0] {
      OP_INS_R  = 3'd0,
      OP_INS_L  = 3'd1,
      OP_DEL_L  = 3'd2,
      OP_DEL_R  = 3'd3,
      OP_PEEK_L = 3'd4,
      OP_PEEK_R = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_OVER   = 2'd1,
      ST_UNDER  = 2'd2,
      ST_DENIED = 2'd3
   } status_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_FREE      = 2'd0,
      MODE_IN_RESTR  = 2'd1,
      MODE_OUT_RESTR = 2'd2
   } mode_type;

   typedef enum logic {
      CS_IDLE = 1'b0,
      CS_LOAD = 1'b1
   } ctrl_state_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;   // request transaction taken this cycle
      logic load;     // capture result into the response register
   } ctrl_cmd_type;

endpackage

`default_nettype wire

// ===== design/cdq_ctrl.sv =====
// Handshake controller for the circular deque: accept, result load, response valid.
// Depends on cdq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cdq_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output cdq_pkg::ctrl_cmd_type cmd
);

   cdq_pkg::ctrl_state_type state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cdq_pkg::CS_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd.accept   = 1'b0;
      cmd.load     = 1'b0;
      req_stall    = 1'b1;
      slot_free    = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         cdq_pkg::CS_IDLE: begin
            // nothing is taken while reset is high
            req_stall = reset;
            if (req_valid && !reset) begin
               cmd.accept = 1'b1;
               state_in   = cdq_pkg::CS_LOAD;
            end
         end
         cdq_pkg::CS_LOAD: begin
            // memory read data is valid now; wait for the output register to drain
            if (slot_free) begin
               cmd.load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = cdq_pkg::CS_IDLE;
            end
         end
         default: state_in = cdq_pkg::CS_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   `ASSERT_NEXT(a_accept_to_load, clock, reset, cmd.accept, state_ff == cdq_pkg::CS_LOAD)
   `ASSERT_IMPLY(a_load_slot_free, clock, reset, cmd.load, !rsp_valid_ff || !rsp_stall)
   `ASSERT_IMPLY(a_valid_from_load, clock, reset, $rose(rsp_valid_ff), $past(cmd.load))

endmodule

`default_nettype wire

// ===== design/cdq_datapath.sv =====
// Datapath of the circular deque: mode register, pointers, entry count,
// storage array and response register. Depends on cdq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cdq_datapath #(
   parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
   input  wire                             clock,
   input  wire                             reset,
   input  cdq_pkg::ctrl_cmd_type           cmd,
   input  wire                             csr_wr_en,
   input  wire  [cdq_pkg::MODE_W-1:0]      csr_restrict_mode,
   input  wire  [cdq_pkg::OP_W-1:0]        req_op,
   input  wire  signed [cdq_pkg::XDATA_W-1:0] req_value,
   output logic signed [cdq_pkg::XDATA_W-1:0] rsp_data,
   output logic [cdq_pkg::STATUS_W-1:0]    rsp_status,
   output logic                            rsp_is_empty,
   output logic                            rsp_is_full,
   output logic [cdq_pkg::OCC_W-1:0]       rsp_occupancy
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [cdq_pkg::MODE_W-1:0] mode_ff;
   logic [PTR_W-1:0]           front_ff, front_in;
   logic [PTR_W-1:0]           rear_ff, rear_in;
   logic [CNT_W-1:0]           count_ff, count_in;

   logic [DATA_WIDTH-1:0]      mem [DEPTH];
   logic [DATA_WIDTH-1:0]      rd_data_ff;
   logic [DATA_WIDTH-1:0]      wr_data;
   logic [PTR_W-1:0]           wr_addr, rd_addr;
   logic                       wr_en, rd_en;

   cdq_pkg::status_type        status_in, status_pend_ff;
   logic                       read_pend_ff;
   logic [cdq_pkg::XDATA_W-1:0] rd_ext;
   logic [cdq_pkg::OCC_W-1:0]  occ_ext;

   logic                       is_empty, is_full;
   cdq_pkg::op_type            op;
   int                         ptr_span;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
   endfunction

   function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
      ptr_dec = (p == '0) ? PTR_LAST : p - PTR_W'(1);
   endfunction

   // width adaptation between port words and stored words
   generate
      if (DATA_WIDTH <= cdq_pkg::XDATA_W) begin : g_wr_narrow
         assign wr_data = req_value[DATA_WIDTH-1:0];
      end else begin : g_wr_wide
         assign wr_data = {{(DATA_WIDTH - cdq_pkg::XDATA_W){req_value[cdq_pkg::XDATA_W-1]}},
                           req_value};
      end
      if (DATA_WIDTH >= cdq_pkg::XDATA_W) begin : g_rd_wide
         assign rd_ext = rd_data_ff[cdq_pkg::XDATA_W-1:0];
      end else begin : g_rd_narrow
         assign rd_ext = {{(cdq_pkg::XDATA_W - DATA_WIDTH){rd_data_ff[DATA_WIDTH-1]}},
                          rd_data_ff};
      end
      if (CNT_W >= cdq_pkg::OCC_W) begin : g_occ_wide
         assign occ_ext = count_ff[cdq_pkg::OCC_W-1:0];
      end else begin : g_occ_narrow
         assign occ_ext = {{(cdq_pkg::OCC_W - CNT_W){1'b0}}, count_ff};
      end
   endgenerate

   assign op       = cdq_pkg::op_type'(req_op);
   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == CNT_FULL);

   always_comb begin
      status_in = cdq_pkg::ST_OK;
      front_in  = front_ff;
      rear_in   = rear_ff;
      count_in  = count_ff;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      wr_addr   = front_ff;
      rd_addr   = front_ff;
      case (op)
         cdq_pkg::OP_INS_R, cdq_pkg::OP_INS_L: begin
            if (op == cdq_pkg::OP_INS_L && mode_ff == cdq_pkg::MODE_IN_RESTR) begin
               status_in = cdq_pkg::ST_DENIED;
            end else if (is_full) begin
               status_in = cdq_pkg::ST_OVER;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
               if (is_empty) begin
                  front_in = '0;
                  rear_in  = '0;
                  wr_addr  = '0;
               end else if (op == cdq_pkg::OP_INS_R) begin
                  rear_in = ptr_inc(rear_ff);
                  wr_addr = ptr_inc(rear_ff);
               end else begin
                  front_in = ptr_dec(front_ff);
                  wr_addr  = ptr_dec(front_ff);
               end
            end
         end
         cdq_pkg::OP_DEL_L, cdq_pkg::OP_DEL_R, cdq_pkg::OP_PEEK_L, cdq_pkg::OP_PEEK_R: begin
            if (op == cdq_pkg::OP_DEL_R && mode_ff == cdq_pkg::MODE_OUT_RESTR) begin
               status_in = cdq_pkg::ST_DENIED;
            end else if (is_empty) begin
               status_in = cdq_pkg::ST_UNDER;
            end else begin
               rd_en   = 1'b1;
               rd_addr = (op == cdq_pkg::OP_DEL_L || op == cdq_pkg::OP_PEEK_L) ?
                         front_ff : rear_ff;
               if (op == cdq_pkg::OP_DEL_L || op == cdq_pkg::OP_DEL_R) begin
                  count_in = count_ff - CNT_W'(1);
                  if (front_ff == rear_ff) begin
                     // last entry gone: pointers go home
                     front_in = '0;
                     rear_in  = '0;
                  end else if (op == cdq_pkg::OP_DEL_L) begin
                     front_in = ptr_inc(front_ff);
                  end else begin
                     rear_in = ptr_dec(rear_ff);
                  end
               end
            end
         end
         default: status_in = cdq_pkg::ST_DENIED;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= cdq_pkg::MODE_FREE;
         front_ff <= '0;
         rear_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_restrict_mode;
         end
         if (cmd.accept) begin
            front_ff <= front_in;
            rear_ff  <= rear_in;
            count_ff <= count_in;
         end
      end
   end

   // storage array, registered read
   always_ff @(posedge clock) begin
      if (cmd.accept && wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.accept && rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // per-transaction info carried to the load cycle
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         status_pend_ff <= status_in;
         read_pend_ff   <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_data      <= read_pend_ff ? rd_ext : '0;
         rsp_status    <= status_pend_ff;
         rsp_is_empty  <= is_empty;
         rsp_is_full   <= is_full;
         rsp_occupancy <= occ_ext;
      end
   end

   // entries between front and rear, inclusive, with wrap
   assign ptr_span = (rear_ff >= front_ff) ? (int'(rear_ff) - int'(front_ff) + 1)
                                           : (int'(rear_ff) + DEPTH - int'(front_ff) + 1);

   `ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= CNT_FULL)
   `ASSERT_IMPLY(a_empty_home, clock, reset, count_ff == '0, front_ff == '0 && rear_ff == '0)
   `ASSERT_IMPLY(a_count_ptrs, clock, reset, count_ff != '0, ptr_span == int'(count_ff))

endmodule

`default_nettype wire

// ===== design/circular_deque_top.sv =====
// Top level of the circular deque: controller plus datapath.
// Depends on cdq_pkg, cdq_ctrl and cdq_datapath.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   req_op, req_value
//   rsp      out        rsp_valid / rsp_stall   rsp_data, rsp_status, rsp_is_empty,
//                                               rsp_is_full, rsp_occupancy
//   csr      in         csr_wr_en               csr_restrict_mode
//
// Each transaction is accepted, then goes through a load step for the registered
// storage read, which fills the response register; no request is taken meanwhile.
// A new request is taken while the previous response still waits in its register.
// Reset is synchronous, active high; no clearing pass, the block is ready right after.
// A stalled response holds the block in its load cycle once the next request is in.
`default_nettype none

module circular_deque_top #(
   parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_wr_en,
   input  wire  [cdq_pkg::MODE_W-1:0]         csr_restrict_mode,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire  [cdq_pkg::OP_W-1:0]           req_op,
   input  wire  signed [cdq_pkg::XDATA_W-1:0] req_value,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic signed [cdq_pkg::XDATA_W-1:0] rsp_data,
   output logic [cdq_pkg::STATUS_W-1:0]       rsp_status,
   output logic                               rsp_is_empty,
   output logic                               rsp_is_full,
   output logic [cdq_pkg::OCC_W-1:0]          rsp_occupancy
);

   cdq_pkg::ctrl_cmd_type cmd;

   cdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   cdq_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .csr_wr_en         (csr_wr_en),
      .csr_restrict_mode (csr_restrict_mode),
      .req_op            (req_op),
      .req_value         (req_value),
      .rsp_data          (rsp_data),
      .rsp_status        (rsp_status),
      .rsp_is_empty      (rsp_is_empty),
      .rsp_is_full       (rsp_is_full),
      .rsp_occupancy     (rsp_occupancy)
   );

endmodule

`default_nettype wire
